### design/lfu_pkg.sv
// lfu_pkg: shared types and constants for the lfu key-value cache
// no dependencies
package lfu_pkg;
  localparam int unsigned ENTRIES_DEF     = 16;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned USE_WIDTH_DEF   = 16;
  localparam int unsigned CMD_WIDTH       = 3;
  localparam int unsigned CAP_WIDTH       = 5;
  localparam int unsigned STAT_WIDTH      = 32;

  localparam logic [CMD_WIDTH-1:0] CMD_GET    = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_PUT    = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_EXISTS = 3'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_WRITE,
    ST_DONE
  } state_e;
endpackage

### design/lfu_ram.sv
// lfu_ram: generic single-port synchronous ram with registered read
// no dependencies
module lfu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### design/lfu_key_value_cache_core.sv
// lfu_key_value_cache_core: top level of the lfu key-value cache
// depends on lfu_pkg and lfu_ram
//
// usage: pulse start_i with cmd_i, key_i and write_value_i while busy_o is low.
// the command word is taken at that edge; busy_o rises the next cycle.
// entries live in one ram holding key, value and use count; valid bits are flops.
// get, put, remove and exists scan all ENTRIES slots, one read per cycle,
// looking for the key and for the lowest-use victim at the same time.
// a put of a new key then writes the lowest free slot in a write state.
// clear and unknown codes skip the scan and go straight to the done state.
// one command at a time, so the next word is taken at the earliest in the
// cycle after the result.
// the result word appears for one cycle with done_o high; it cannot stall.
// cfg_we_i writes capacity from cfg_wdata_i; write it only while idle.
// reset clears valid bits, statistics and sets capacity to 16. no clearing
// pass is needed since invalid entries are ignored during the scan.
module lfu_key_value_cache_core #(
  parameter int unsigned ENTRIES     = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_WIDTH   = lfu_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = lfu_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned USE_WIDTH   = lfu_pkg::USE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [lfu_pkg::CMD_WIDTH-1:0]   cmd_i,
  input  logic [KEY_WIDTH-1:0]            key_i,
  input  logic [VALUE_WIDTH-1:0]          write_value_i,
  input  logic                            cfg_we_i,
  input  logic [lfu_pkg::CAP_WIDTH-1:0]   cfg_wdata_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic [VALUE_WIDTH-1:0]          read_value_o,
  output logic                            evicted_o,
  output logic [KEY_WIDTH-1:0]            evicted_key_o,
  output logic [lfu_pkg::CAP_WIDTH-1:0]   occupancy_o,
  output logic [lfu_pkg::STAT_WIDTH-1:0]  request_count_o,
  output logic [lfu_pkg::STAT_WIDTH-1:0]  hit_count_o,
  output logic [lfu_pkg::STAT_WIDTH-1:0]  miss_count_o,
  output logic [lfu_pkg::STAT_WIDTH-1:0]  eviction_count_o
);
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned RW = KEY_WIDTH + VALUE_WIDTH + USE_WIDTH;
  localparam int unsigned SW = lfu_pkg::STAT_WIDTH;
  localparam logic [USE_WIDTH-1:0] USE_MAX = {USE_WIDTH{1'b1}};
  localparam logic [SW-1:0] STAT_MAX = {SW{1'b1}};
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  lfu_pkg::state_e state_q, state_d;
  logic [lfu_pkg::CAP_WIDTH-1:0] cap_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [lfu_pkg::CMD_WIDTH-1:0] cmd_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [VALUE_WIDTH-1:0] wval_q;
  logic [AW-1:0] addr_q, addr_d, rd_idx_q;
  logic rd_vld_q, rd_vld_d;
  logic found_q, found_d;
  logic [AW-1:0] fslot_q, fslot_d;
  logic [USE_WIDTH-1:0] fuses_q, fuses_d;
  logic [VALUE_WIDTH-1:0] fval_q, fval_d;
  logic vic_q, vic_d;
  logic [AW-1:0] vslot_q, vslot_d;
  logic [USE_WIDTH-1:0] vuses_q, vuses_d;
  logic [KEY_WIDTH-1:0] vkey_q, vkey_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [SW-1:0] req_q, req_d, hit_cnt_q, hit_cnt_d, miss_q, miss_d, evc_q, evc_d;
  logic r_hit_q, r_hit_d, r_ev_q, r_ev_d;
  logic [VALUE_WIDTH-1:0] r_val_q, r_val_d;
  logic [KEY_WIDTH-1:0] r_evk_q, r_evk_d;
  logic [AW-1:0] free_q, free_d;
  logic free_ok_q, free_ok_d;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [USE_WIDTH-1:0] rd_uses;
  logic [CW-1:0] eff_cap;

  assign {rd_key, rd_val, rd_uses} = ram_rdata;

  lfu_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (32'(cap_q) > ENTRIES) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(cap_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lfu_pkg::ST_IDLE;
      cap_q     <= lfu_pkg::CAP_WIDTH'(16);
      valid_q   <= '0;
      occ_q     <= '0;
      req_q     <= '0;
      hit_cnt_q <= '0;
      miss_q    <= '0;
      evc_q     <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      occ_q     <= occ_d;
      req_q     <= req_d;
      hit_cnt_q <= hit_cnt_d;
      miss_q    <= miss_d;
      evc_q     <= evc_d;
      rd_vld_q  <= rd_vld_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == lfu_pkg::ST_IDLE) begin
      cmd_q  <= cmd_i;
      key_q  <= key_i;
      wval_q <= write_value_i;
    end
    addr_q    <= addr_d;
    rd_idx_q  <= addr_q;
    found_q   <= found_d;
    fslot_q   <= fslot_d;
    fuses_q   <= fuses_d;
    fval_q    <= fval_d;
    vic_q     <= vic_d;
    vslot_q   <= vslot_d;
    vuses_q   <= vuses_d;
    vkey_q    <= vkey_d;
    r_hit_q   <= r_hit_d;
    r_ev_q    <= r_ev_d;
    r_val_q   <= r_val_d;
    r_evk_q   <= r_evk_d;
    free_q    <= free_d;
    free_ok_q <= free_ok_d;
  end

  always_comb begin
    logic [ENTRIES-1:0] v;
    logic [CW-1:0] n;
    state_d   = state_q;
    valid_d   = valid_q;
    occ_d     = occ_q;
    req_d     = req_q;
    hit_cnt_d = hit_cnt_q;
    miss_d    = miss_q;
    evc_d     = evc_q;
    addr_d    = addr_q;
    rd_vld_d  = 1'b0;
    found_d   = found_q;
    fslot_d   = fslot_q;
    fuses_d   = fuses_q;
    fval_d    = fval_q;
    vic_d     = vic_q;
    vslot_d   = vslot_q;
    vuses_d   = vuses_q;
    vkey_d    = vkey_q;
    r_hit_d   = r_hit_q;
    r_ev_d    = r_ev_q;
    r_val_d   = r_val_q;
    r_evk_d   = r_evk_q;
    free_d    = free_q;
    free_ok_d = free_ok_q;
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = {key_q, wval_q, USE_WIDTH'(1)};
    v         = valid_q;
    n         = occ_q;
    done_o    = 1'b0;
    case (state_q)
      lfu_pkg::ST_IDLE: begin
        if (start_i) begin
          addr_d  = '0;
          found_d = 1'b0;
          vic_d   = 1'b0;
          r_hit_d = 1'b0;
          r_ev_d  = 1'b0;
          r_val_d = '0;
          r_evk_d = '0;
          if (cmd_i == lfu_pkg::CMD_GET || cmd_i == lfu_pkg::CMD_PUT ||
              cmd_i == lfu_pkg::CMD_REMOVE || cmd_i == lfu_pkg::CMD_EXISTS) begin
            state_d = lfu_pkg::ST_SCAN;
          end else begin
            if (cmd_i == lfu_pkg::CMD_CLEAR) begin
              valid_d = '0;
              occ_d   = '0;
            end
            state_d = lfu_pkg::ST_DONE;
          end
        end
      end
      lfu_pkg::ST_SCAN: begin
        ram_addr = addr_q;
        rd_vld_d = 1'b1;
        if (addr_q != LAST) begin
          addr_d = addr_q + AW'(1);
        end
        // process the word read last cycle (index rd_idx_q)
        if (rd_vld_q && valid_q[rd_idx_q]) begin
          if (rd_key == key_q && !found_q) begin
            found_d = 1'b1;
            fslot_d = rd_idx_q;
            fuses_d = rd_uses;
            fval_d  = rd_val;
          end
          if (!vic_q || rd_uses < vuses_q) begin
            vic_d   = 1'b1;
            vslot_d = rd_idx_q;
            vuses_d = rd_uses;
            vkey_d  = rd_key;
          end
        end
        if (rd_vld_q && rd_idx_q == LAST) begin
          state_d = lfu_pkg::ST_FREE;
        end
      end
      lfu_pkg::ST_FREE: begin
        ram_addr = fslot_q;
        case (cmd_q)
          lfu_pkg::CMD_GET: begin
            req_d = (req_q == STAT_MAX) ? req_q : req_q + SW'(1);
            if (found_q) begin
              hit_cnt_d = (hit_cnt_q == STAT_MAX) ? hit_cnt_q : hit_cnt_q + SW'(1);
              r_hit_d   = 1'b1;
              r_val_d   = fval_q;
              ram_we    = 1'b1;
              ram_wdata = {key_q, fval_q,
                           (fuses_q == USE_MAX) ? fuses_q : fuses_q + USE_WIDTH'(1)};
            end else begin
              miss_d = (miss_q == STAT_MAX) ? miss_q : miss_q + SW'(1);
            end
            state_d = lfu_pkg::ST_DONE;
          end
          lfu_pkg::CMD_PUT: begin
            if (found_q) begin
              ram_we    = 1'b1;
              ram_wdata = {key_q, wval_q,
                           (fuses_q == USE_MAX) ? fuses_q : fuses_q + USE_WIDTH'(1)};
              state_d   = lfu_pkg::ST_DONE;
            end else begin
              if (occ_q >= eff_cap && vic_q) begin
                v[vslot_q] = 1'b0;
                n          = occ_q - CW'(1);
                r_ev_d     = 1'b1;
                r_evk_d    = vkey_q;
                evc_d      = (evc_q == STAT_MAX) ? evc_q : evc_q + SW'(1);
              end
              valid_d   = v;
              occ_d     = n;
              free_ok_d = 1'b0;
              free_d    = '0;
              for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!v[i]) begin
                  free_ok_d = 1'b1;
                  free_d    = AW'(i);
                end
              end
              state_d = lfu_pkg::ST_WRITE;
            end
          end
          lfu_pkg::CMD_REMOVE: begin
            if (found_q) begin
              valid_d[fslot_q] = 1'b0;
              occ_d            = occ_q - CW'(1);
            end
            state_d = lfu_pkg::ST_DONE;
          end
          lfu_pkg::CMD_EXISTS: begin
            r_hit_d = found_q;
            state_d = lfu_pkg::ST_DONE;
          end
          default: begin
            state_d = lfu_pkg::ST_DONE;
          end
        endcase
      end
      lfu_pkg::ST_WRITE: begin
        ram_addr = free_q;
        if (free_ok_q) begin
          ram_we          = 1'b1;
          valid_d[free_q] = 1'b1;
          occ_d           = occ_q + CW'(1);
        end
        state_d = lfu_pkg::ST_DONE;
      end
      lfu_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = lfu_pkg::ST_IDLE;
      end
      default: begin
        state_d = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o           = (state_q != lfu_pkg::ST_IDLE);
  assign hit_o            = r_hit_q;
  assign read_value_o     = r_val_q;
  assign evicted_o        = r_ev_q;
  assign evicted_key_o    = r_evk_q;
  assign occupancy_o      = lfu_pkg::CAP_WIDTH'(occ_q);
  assign request_count_o  = req_q;
  assign hit_count_o      = hit_cnt_q;
  assign miss_count_o     = miss_q;
  assign eviction_count_o = evc_q;
endmodule
